[rtl/rye_pkg.sv]
package rye_pkg;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic REG_MODE = 1'b0;

  localparam logic [1:0] MODE_GRAY  = 2'd0;
  localparam logic [1:0] MODE_UNDER = 2'd1;
  localparam logic [1:0] MODE_OVER  = 2'd2;

  localparam logic [7:0] BYTE_MAX = 8'd255;

  // floor(y*5/6) = (y*13655) >> 14 and floor(y*6/5) = (y*19662) >> 14 for y < 512
  localparam int GAIN_SHIFT = 14;
  localparam int GAIN_K_W = 15;
  localparam logic [GAIN_K_W-1:0] GAIN_DOWN_K = 15'd13655;
  localparam logic [GAIN_K_W-1:0] GAIN_UP_K   = 15'd19662;

  typedef struct packed {
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
  } pix_out_t;

  typedef struct packed {
    logic [8:0]        y;
    logic signed [9:0] u;
    logic signed [9:0] v;
  } yuv_t;

endpackage

[rtl/rgb_yuv_exposure_adjust_unit.sv]
// RGB to YUV exposure adjust.
// Input channel: in_valid/in_ready carry one BGR pixel per beat (in_data).
// Output channel: out_valid/out_ready carry one BGR result per beat (out_data).
// Register exposure_mode at byte address 0 of the APB port: 0 grayscale,
// 1 luma times 5/6, 2 luma times 6/5 clamped at 255, 3 grayscale.
// Change the mode only while the pipeline is empty.
// Four register stages (products, yuv sums, gain and chroma products, back
// conversion into the output register). Throughput: one pixel per clock
// while out_ready is high; each stage is one multiply or one add.
// When out_ready is low, stages fill up one by one and in_ready drops once
// all four hold a beat; nothing is dropped or repeated.
// Reset (rst, synchronous) empties the pipeline and sets the mode to 0.
module rgb_yuv_exposure_adjust_unit #(
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rye_pkg::pix_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rye_pkg::pix_out_t             out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rye_pkg::ADDR_W-1:0]    paddr,
  input  logic [rye_pkg::DATA_W-1:0]    pwdata,
  output logic [rye_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import rye_pkg::*;

  logic [1:0] mode;
  logic       reg_hit;
  logic       yuv_valid, yuv_ready;
  yuv_t       yuv_data;

  assign reg_hit = (paddr[ADDR_W-1:2] == REG_MODE);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? DATA_W'(mode) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_GRAY;
    end else if (psel && penable && pwrite && reg_hit) begin
      mode <= pwdata[1:0];
    end
  end

  rye_fwd #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_fwd (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(yuv_valid),
    .out_ready(yuv_ready),
    .out_data (yuv_data)
  );

  rye_back #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .mode     (mode),
    .in_valid (yuv_valid),
    .in_ready (yuv_ready),
    .in_data  (yuv_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

[rtl/rye_fwd.sv]
module rye_fwd #(
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rye_pkg::pix_in_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rye_pkg::yuv_t   out_data
);
  import rye_pkg::*;

  localparam int F  = COEF_FRAC_BITS;
  localparam int PW = F + 8;
  localparam int SW = F + 11;

  localparam logic [PW-1:0] C_YB = PW'((114 * (1 << F) + 500) / 1000);
  localparam logic [PW-1:0] C_YG = PW'((587 * (1 << F) + 500) / 1000);
  localparam logic [PW-1:0] C_YR = PW'((299 * (1 << F) + 500) / 1000);
  localparam logic [PW-1:0] C_UB = PW'((435 * (1 << F) + 500) / 1000);
  localparam logic [PW-1:0] C_UG = PW'((289 * (1 << F) + 500) / 1000);
  localparam logic [PW-1:0] C_UR = PW'((147 * (1 << F) + 500) / 1000);
  localparam logic [PW-1:0] C_VB = PW'((100 * (1 << F) + 500) / 1000);
  localparam logic [PW-1:0] C_VG = PW'((515 * (1 << F) + 500) / 1000);
  localparam logic [PW-1:0] C_VR = PW'((615 * (1 << F) + 500) / 1000);

  function automatic logic signed [9:0] trunc0(input logic signed [SW-1:0] acc);
    logic [SW-1:0] mag;
    logic [9:0]    q;
    mag = acc[SW-1] ? SW'(-acc) : acc;
    q = mag[F+9:F];
    trunc0 = acc[SW-1] ? -$signed(q) : $signed(q);
  endfunction

  logic s1_v, s2_v;
  logic s1_en, s2_en;
  logic [PW-1:0] p_yb, p_yg, p_yr, p_ub, p_ug, p_ur, p_vb, p_vg, p_vr;
  logic [SW-1:0] y_sum;
  logic signed [SW-1:0] u_acc, v_acc;
  yuv_t s2_data, s2_next;

  assign s2_en    = !s2_v || out_ready;
  assign s1_en    = !s1_v || s2_en;
  assign in_ready = s1_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v <= in_valid;
      end
      if (s2_en) begin
        s2_v <= s1_v;
      end
    end
  end

  // stage 1: coefficient products
  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      p_yb <= PW'(in_data.blue_in) * C_YB;
      p_yg <= PW'(in_data.green_in) * C_YG;
      p_yr <= PW'(in_data.red_in) * C_YR;
      p_ub <= PW'(in_data.blue_in) * C_UB;
      p_ug <= PW'(in_data.green_in) * C_UG;
      p_ur <= PW'(in_data.red_in) * C_UR;
      p_vb <= PW'(in_data.blue_in) * C_VB;
      p_vg <= PW'(in_data.green_in) * C_VG;
      p_vr <= PW'(in_data.red_in) * C_VR;
    end
  end

  // stage 2: sums, truncate toward zero
  always_comb begin
    y_sum = SW'(p_yb) + SW'(p_yg) + SW'(p_yr);
    u_acc = $signed(SW'(p_ub)) - $signed(SW'(p_ug)) - $signed(SW'(p_ur));
    v_acc = $signed(SW'(p_vr)) - $signed(SW'(p_vb)) - $signed(SW'(p_vg));
    s2_next.y = y_sum[F+8:F];
    s2_next.u = trunc0(u_acc);
    s2_next.v = trunc0(v_acc);
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_v) begin
      s2_data <= s2_next;
    end
  end

  assign out_valid = s2_v;
  assign out_data  = s2_data;

  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_v)
    else $error("accepted beat did not reach stage 1");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    s2_v && !out_ready |=> s2_v && $stable(s2_data))
    else $error("stalled yuv stage changed");

endmodule

[rtl/rye_back.sv]
module rye_back #(
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       mode,
  input  logic             in_valid,
  output logic             in_ready,
  input  rye_pkg::yuv_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rye_pkg::pix_out_t out_data
);
  import rye_pkg::*;

  localparam int F    = COEF_FRAC_BITS;
  localparam int CW   = F + 3;
  localparam int MW   = F + 13;
  localparam int AW   = F + 14;
  localparam int GP_W = 9 + GAIN_K_W;

  localparam logic signed [CW-1:0] C_BU = CW'((2032 * (1 << F) + 500) / 1000);
  localparam logic signed [CW-1:0] C_GU = CW'((395 * (1 << F) + 500) / 1000);
  localparam logic signed [CW-1:0] C_GV = CW'((581 * (1 << F) + 500) / 1000);
  localparam logic signed [CW-1:0] C_RV = CW'((1140 * (1 << F) + 500) / 1000);

  function automatic logic [7:0] sat_byte(input logic signed [AW-1:0] acc);
    logic [AW-1:0] q;
    q = acc >>> F;
    if (acc[AW-1]) begin
      sat_byte = '0;
    end else if (q > AW'(BYTE_MAX)) begin
      sat_byte = BYTE_MAX;
    end else begin
      sat_byte = q[7:0];
    end
  endfunction

  logic s3_v, s4_v;
  logic s3_en, s4_en;
  logic adjust, over;
  logic [GAIN_K_W-1:0] kmul;
  logic [GP_W-1:0] g_prod;
  logic [9:0] g_q;
  logic [8:0] y_adj_next;

  logic [8:0] y_adj;
  logic [7:0] gray;
  logic       bypass;
  logic signed [MW-1:0] m_bu, m_gu, m_gv, m_rv;

  logic signed [AW-1:0] ys, acc_b, acc_g, acc_r;
  pix_out_t out_next;

  assign s4_en    = !s4_v || out_ready;
  assign s3_en    = !s3_v || s4_en;
  assign in_ready = s3_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else begin
      if (s3_en) begin
        s3_v <= in_valid;
      end
      if (s4_en) begin
        s4_v <= s3_v;
      end
    end
  end

  // stage 3: luma gain, chroma products
  always_comb begin
    over   = (mode == MODE_OVER);
    adjust = (mode == MODE_UNDER) || over;
    kmul   = over ? GAIN_UP_K : GAIN_DOWN_K;
    g_prod = GP_W'(in_data.y) * GP_W'(kmul);
    g_q    = g_prod[GP_W-1:GAIN_SHIFT];
    if (over && g_q > 10'(BYTE_MAX)) begin
      y_adj_next = 9'(BYTE_MAX);
    end else begin
      y_adj_next = g_q[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en && in_valid) begin
      y_adj  <= y_adj_next;
      gray   <= (in_data.y > 9'(BYTE_MAX)) ? BYTE_MAX : in_data.y[7:0];
      bypass <= !adjust;
      m_bu   <= $signed(MW'(in_data.u)) * $signed(MW'(C_BU));
      m_gu   <= $signed(MW'(in_data.u)) * $signed(MW'(C_GU));
      m_gv   <= $signed(MW'(in_data.v)) * $signed(MW'(C_GV));
      m_rv   <= $signed(MW'(in_data.v)) * $signed(MW'(C_RV));
    end
  end

  // stage 4: back to bgr, saturate
  always_comb begin
    ys    = $signed(AW'(y_adj)) <<< F;
    acc_b = ys + AW'(m_bu);
    acc_g = ys - AW'(m_gu) - AW'(m_gv);
    acc_r = ys + AW'(m_rv);
    if (bypass) begin
      out_next.blue_out  = gray;
      out_next.green_out = gray;
      out_next.red_out   = gray;
    end else begin
      out_next.blue_out  = sat_byte(acc_b);
      out_next.green_out = sat_byte(acc_g);
      out_next.red_out   = sat_byte(acc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (s4_en && s3_v) begin
      out_data <= out_next;
    end
  end

  assign out_valid = s4_v;

  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s3_v)
    else $error("accepted beat did not reach stage 3");

  a_luma_range: assert property (@(posedge clk) disable iff (rst)
    s3_v |-> y_adj <= 9'(BYTE_MAX))
    else $error("adjusted luma above byte range");

  a_gray: assert property (@(posedge clk) disable iff (rst)
    s4_en && s3_v && bypass |=>
      out_data.blue_out == out_data.green_out && out_data.green_out == out_data.red_out)
    else $error("grayscale beat with unequal channels");

endmodule
